// File: hw/rtl/ffha_pkg.sv
// Shared constants and types of the first-fit heap allocator.
// Used by ffha_store and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

    localparam int ARENA_BYTES      = 16384;
    localparam int HEADER_BYTES     = 16;
    localparam int ALIGN_BYTES      = 8;
    localparam int ARENA_SIZE_RESET = 16384;

    localparam int WORDS     = ARENA_BYTES / ALIGN_BYTES;
    localparam int HDR_SPAN  = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int HDR_WORDS = HDR_SPAN / ALIGN_BYTES;
    localparam int IDX_W     = $clog2(WORDS);
    localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
    localparam int SIZE_W    = 15;
    localparam int ADDR_W    = 14;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic
    {
        STATUS_DONE  = 1'b0,
        STATUS_NOFIT = 1'b1
    } status_t;

    typedef struct packed
    {
        logic valid;
        idx_t next;
    } link_t;

    // One access to the header store: read at addr every cycle, optional writes.
    typedef struct packed
    {
        logic              size_we;
        logic              link_we;
        idx_t              addr;
        logic [SIZE_W-1:0] size;
        link_t             link;
    } store_req_t;

endpackage

// File: hw/rtl/ffha_store.sv
// Header store of the allocator: block sizes and free-list links per alignment word.
// Single port, read-first, registered read data. Depends on ffha_pkg.
module ffha_store
(
    input  logic                      clk,
    input  ffha_pkg::store_req_t      req,
    output logic [ffha_pkg::SIZE_W-1:0] rd_size,
    output ffha_pkg::link_t           rd_link
);

    logic [ffha_pkg::SIZE_W-1:0] size_mem [ffha_pkg::WORDS];
    ffha_pkg::link_t             link_mem [ffha_pkg::WORDS];

    logic [ffha_pkg::SIZE_W-1:0] rd_size_reg;
    ffha_pkg::link_t             rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (req.size_we)
        begin
            size_mem[req.addr] <= req.size;
        end
        rd_size_reg <= size_mem[req.addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.addr] <= req.link;
        end
        rd_link_reg <= link_mem[req.addr];
    end

    assign rd_size = rd_size_reg;
    assign rd_link = rd_link_reg;

endmodule

// File: hw/rtl/first_fit_heap_allocator.sv
// First-fit free-list heap allocator: sequencer, shared subtractor and result register.
// Depends on ffha_pkg and ffha_store.
//
//  Channel   Dir  Handshake            Beat contents
//  in        in   in_valid / in_stall  op, request_size, block_address
//  out       out  out_valid / out_stall data_address, status
//  config    in   arena_size_we        arena_size
//
// A free passes through accept, ST_FREE and ST_DONE. An allocate visits each header on the walk
// in ST_LOOK and ST_EVAL (one header store read and one evaluation in the shared subtractor),
// then unlinks a whole block in ST_LINK and ST_UNLINK or splits one in ST_SPLIT_NEW, ST_SPLIT_CUR,
// ST_LINK and ST_UNLINK, before ST_DONE; a walk off the end of the list passes ST_LOOK once more.
// After reset and after every arena_size write a clearing pass sweeps all 2048 entries of
// the header store, one entry a cycle; no input beat is taken meanwhile.
// A result waits in the output register while out_stall is high; the next beat
// is taken meanwhile, and its result holds until the register frees.
module first_fit_heap_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                arena_size_we,
    input  logic [ffha_pkg::SIZE_W-1:0]         arena_size,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [ffha_pkg::ADDR_W-1:0]         request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]         block_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ffha_pkg::ADDR_W-1:0]         data_address,
    output logic                                status
);

    localparam int NW_W = ffha_pkg::IDX_W + 2;
    localparam int CNT_W = ffha_pkg::IDX_W + 1;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_SPLIT_NEW,
        ST_SPLIT_CUR,
        ST_LINK,
        ST_UNLINK,
        ST_FREE,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [ffha_pkg::SIZE_W-1:0]     arena_size_reg;
    ffha_pkg::idx_t                  clr_idx_reg;
    ffha_pkg::idx_t                  head_reg;
    logic                            head_valid_reg;
    ffha_pkg::idx_t                  cur_reg;
    logic                            cur_ok_reg;
    ffha_pkg::idx_t                  prev_reg;
    logic                            have_prev_reg;
    logic [CNT_W-1:0]                steps_reg;
    logic [ffha_pkg::SIZE_W-1:0]     want_reg;
    logic [ffha_pkg::SIZE_W-1:0]     diff_reg;
    ffha_pkg::link_t                 link_cur_reg;
    ffha_pkg::link_t                 rep_reg;
    ffha_pkg::idx_t                  nw_reg;
    logic [ffha_pkg::ADDR_W-1:0]     addr_reg;
    logic [ffha_pkg::ADDR_W-1:0]     res_addr_reg;
    logic                            res_status_reg;
    logic                            out_valid_reg;
    logic [ffha_pkg::ADDR_W-1:0]     data_address_reg;
    logic                            status_reg;

    logic [ffha_pkg::SIZE_W-1:0]     clip;
    logic [ffha_pkg::SIZE_W-1:0]     ext;
    logic [ffha_pkg::SIZE_W-1:0]     want_next;
    logic [ffha_pkg::SIZE_W-1:0]     alu_a;
    logic [ffha_pkg::SIZE_W-1:0]     alu_b;
    logic [ffha_pkg::SIZE_W:0]       alu_diff;
    logic                            alu_neg;
    logic                            fit;
    logic                            split;
    logic [NW_W-1:0]                 nw_sum;
    logic                            nw_over;
    logic [ffha_pkg::ADDR_W-1:0]     hb;
    logic                            free_ok;
    ffha_pkg::idx_t                  free_idx;
    logic [ffha_pkg::ADDR_W-1:0]     cur_data_addr;
    logic                            out_free;
    logic                            out_load;

    ffha_pkg::store_req_t            store_req;
    logic [ffha_pkg::SIZE_W-1:0]     rd_size;
    ffha_pkg::link_t                 rd_link;

    ffha_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .rd_size (rd_size),
        .rd_link (rd_link)
    );

    // Arena extent: clip to the arena and round down to the alignment.
    always_comb
    begin
        if (int'(arena_size_reg) > ffha_pkg::ARENA_BYTES)
        begin
            clip = ffha_pkg::SIZE_W'(ffha_pkg::ARENA_BYTES);
        end
        else
        begin
            clip = arena_size_reg;
        end
        ext = clip & ~ffha_pkg::SIZE_W'(ffha_pkg::ALIGN_BYTES - 1);
    end

    assign want_next = (ffha_pkg::SIZE_W'(request_size) + ffha_pkg::SIZE_W'(ffha_pkg::ALIGN_BYTES - 1))
                       & ~ffha_pkg::SIZE_W'(ffha_pkg::ALIGN_BYTES - 1);

    // Shared subtractor: fit test, remainder size, extent checks.
    always_comb
    begin
        unique case (state_reg)
            ST_EVAL:
            begin
                alu_a = rd_size;
                alu_b = want_reg;
            end
            ST_SPLIT_NEW:
            begin
                alu_a = diff_reg;
                alu_b = ffha_pkg::SIZE_W'(ffha_pkg::HDR_SPAN);
            end
            ST_FREE:
            begin
                alu_a = ext;
                alu_b = ffha_pkg::SIZE_W'(addr_reg);
            end
            default:
            begin
                alu_a = ext;
                alu_b = ffha_pkg::SIZE_W'(ffha_pkg::HDR_SPAN);
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_neg  = alu_diff[ffha_pkg::SIZE_W];

    assign fit   = !alu_neg;
    assign split = fit && (alu_diff[ffha_pkg::SIZE_W-1:0]
                   >= ffha_pkg::SIZE_W'(ffha_pkg::HDR_SPAN + ffha_pkg::ALIGN_BYTES));

    assign nw_sum  = NW_W'(cur_reg) + NW_W'(ffha_pkg::HDR_WORDS)
                     + NW_W'(want_reg >> ffha_pkg::ALIGN_SH);
    assign nw_over = (nw_sum >= NW_W'(ffha_pkg::WORDS));

    assign hb       = addr_reg - ffha_pkg::ADDR_W'(ffha_pkg::HDR_SPAN);
    assign free_ok  = (int'(addr_reg) >= ffha_pkg::HDR_SPAN)
                      && (hb[ffha_pkg::ALIGN_SH-1:0] == '0) && !alu_neg;
    assign free_idx = ffha_pkg::IDX_W'(hb >> ffha_pkg::ALIGN_SH);

    assign cur_data_addr = ffha_pkg::ADDR_W'({cur_reg, {ffha_pkg::ALIGN_SH{1'b0}}})
                           + ffha_pkg::ADDR_W'(ffha_pkg::HDR_SPAN);

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_DONE) && out_free && !arena_size_we;

    always_comb
    begin
        store_req         = '0;
        store_req.addr    = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                store_req.size_we = 1'b1;
                store_req.link_we = 1'b1;
                store_req.addr    = clr_idx_reg;
                // the last entry swept is entry zero, which gets the arena extent less one header span
                if (clr_idx_reg == '0 && !alu_neg)
                begin
                    store_req.size = alu_diff[ffha_pkg::SIZE_W-1:0];
                end
            end
            ST_SPLIT_NEW:
            begin
                store_req.size_we = 1'b1;
                store_req.link_we = 1'b1;
                store_req.addr    = nw_reg;
                store_req.size    = alu_diff[ffha_pkg::SIZE_W-1:0];
                store_req.link    = link_cur_reg;
            end
            ST_SPLIT_CUR:
            begin
                store_req.size_we = 1'b1;
                store_req.size    = want_reg;
            end
            ST_LINK:
            begin
                if (have_prev_reg)
                begin
                    store_req.link_we = 1'b1;
                    store_req.addr    = prev_reg;
                    store_req.link    = rep_reg;
                end
            end
            ST_UNLINK:
            begin
                store_req.link_we = 1'b1;
            end
            ST_FREE:
            begin
                if (free_ok)
                begin
                    store_req.link_we    = 1'b1;
                    store_req.addr       = free_idx;
                    store_req.link.valid = head_valid_reg;
                    store_req.link.next  = head_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            arena_size_reg <= ffha_pkg::SIZE_W'(ffha_pkg::ARENA_SIZE_RESET);
            clr_idx_reg    <= ffha_pkg::IDX_W'(ffha_pkg::WORDS - 1);
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            cur_ok_reg     <= 1'b0;
            have_prev_reg  <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // load a new result or hold the waiting one while stalled
            out_valid_reg <= out_load || (out_valid_reg && out_stall);

            if (arena_size_we)
            begin
                arena_size_reg <= arena_size;
                clr_idx_reg    <= ffha_pkg::IDX_W'(ffha_pkg::WORDS - 1);
                state_reg      <= ST_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    ST_CLEAR:
                    begin
                        if (clr_idx_reg == '0)
                        begin
                            head_reg       <= '0;
                            head_valid_reg <= !alu_neg;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            clr_idx_reg <= clr_idx_reg - 1'b1;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_valid)
                        begin
                            if (op == ffha_pkg::OP_FREE)
                            begin
                                addr_reg  <= block_address;
                                state_reg <= ST_FREE;
                            end
                            else
                            begin
                                want_reg      <= want_next;
                                cur_reg       <= head_reg;
                                cur_ok_reg    <= head_valid_reg;
                                have_prev_reg <= 1'b0;
                                steps_reg     <= '0;
                                state_reg     <= ST_LOOK;
                            end
                        end
                    end
                    ST_LOOK:
                    begin
                        // end of list or walk limit: no fit
                        if (!cur_ok_reg || steps_reg == CNT_W'(ffha_pkg::WORDS))
                        begin
                            res_addr_reg   <= '0;
                            res_status_reg <= ffha_pkg::STATUS_NOFIT;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_EVAL;
                        end
                    end
                    ST_EVAL:
                    begin
                        if (fit)
                        begin
                            link_cur_reg <= rd_link;
                            diff_reg     <= alu_diff[ffha_pkg::SIZE_W-1:0];
                            if (split)
                            begin
                                if (nw_over)
                                begin
                                    res_addr_reg   <= '0;
                                    res_status_reg <= ffha_pkg::STATUS_NOFIT;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    nw_reg        <= nw_sum[ffha_pkg::IDX_W-1:0];
                                    rep_reg.valid <= 1'b1;
                                    rep_reg.next  <= nw_sum[ffha_pkg::IDX_W-1:0];
                                    state_reg     <= ST_SPLIT_NEW;
                                end
                            end
                            else
                            begin
                                rep_reg   <= rd_link;
                                state_reg <= ST_LINK;
                            end
                        end
                        else
                        begin
                            // advance to the next free block
                            prev_reg      <= cur_reg;
                            have_prev_reg <= 1'b1;
                            cur_reg       <= rd_link.next;
                            cur_ok_reg    <= rd_link.valid;
                            steps_reg     <= steps_reg + 1'b1;
                            state_reg     <= ST_LOOK;
                        end
                    end
                    ST_SPLIT_NEW:
                    begin
                        state_reg <= ST_SPLIT_CUR;
                    end
                    ST_SPLIT_CUR:
                    begin
                        state_reg <= ST_LINK;
                    end
                    ST_LINK:
                    begin
                        if (!have_prev_reg)
                        begin
                            head_reg       <= rep_reg.next;
                            head_valid_reg <= rep_reg.valid;
                        end
                        state_reg <= ST_UNLINK;
                    end
                    ST_UNLINK:
                    begin
                        res_addr_reg   <= cur_data_addr;
                        res_status_reg <= ffha_pkg::STATUS_DONE;
                        state_reg      <= ST_DONE;
                    end
                    ST_FREE:
                    begin
                        if (free_ok)
                        begin
                            head_reg       <= free_idx;
                            head_valid_reg <= 1'b1;
                        end
                        res_addr_reg   <= '0;
                        res_status_reg <= ffha_pkg::STATUS_DONE;
                        state_reg      <= ST_DONE;
                    end
                    ST_DONE:
                    begin
                        // hold until the output register frees
                        if (out_free)
                        begin
                            data_address_reg <= res_addr_reg;
                            status_reg       <= res_status_reg;
                            state_reg        <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign data_address = data_address_reg;
    assign status       = status_reg;

    a_fail_has_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ffha_pkg::STATUS_NOFIT) |-> (data_address == '0))
        else $error("no-fit result carries an address");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg <= CNT_W'(ffha_pkg::WORDS)))
        else $error("walk counter passed its limit");

    a_split_above_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT_NEW) |-> (nw_reg > cur_reg))
        else $error("split remainder not above its block");

    a_free_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE && free_ok && !arena_size_we)
            |=> (head_valid_reg && state_reg == ST_DONE))
        else $error("accepted free did not land on the list head");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        $past(arena_size_we) |-> (state_reg == ST_CLEAR && in_stall))
        else $error("input taken during the clearing pass");

endmodule
